// File: hdl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes, codes and the records that pass along the frame chain and
// from the controller to every frame cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 16;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = IDX_W;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [RANK_W-1:0]    rank_t;

  typedef enum logic [1:0] {
    OC_HIT     = 2'd0,
    OC_FILL    = 2'd1,
    OC_REPLACE = 2'd2
  } outcome_t;

  // Running search record, handed from one frame cell to the next.
  typedef struct packed {
    logic  hit;
    idx_t  hit_idx;
    rank_t hit_rank;
    logic  empty;
    idx_t  empty_idx;
    logic  lru_seen;
    idx_t  lru_idx;
    rank_t lru_rank;
    page_t lru_page;
  } scan_t;

  // Update command broadcast to all frame cells once a search has finished.
  typedef struct packed {
    logic  en;
    idx_t  sel_idx;
    logic  set_page;
    logic  set_valid;
    logic  age_all;
    rank_t old_rank;
    page_t page;
  } upd_t;

endpackage

`default_nettype wire

// File: hdl/lrupr_cell.sv
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame (page, valid mark, recency rank), adds its view to the
// search record passing by and applies the broadcast update command.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cell
  import lrupr_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  idx_t  idx,
  input  wire   active,
  input  wire   tok_in,
  input  page_t page_in,
  input  scan_t carry_in,
  input  upd_t  upd,
  output logic  tok_out,
  output scan_t carry_out
);

  page_t frame_page;
  logic  frame_valid;
  rank_t frame_rank;
  scan_t carry_next;
  logic  sel;

  always_comb begin
    carry_next = carry_in;
    if (active) begin
      if (frame_valid && (frame_page == page_in) && !carry_in.hit) begin
        carry_next.hit      = 1'b1;
        carry_next.hit_idx  = idx;
        carry_next.hit_rank = frame_rank;
      end
      if (!frame_valid && !carry_in.empty) begin
        carry_next.empty     = 1'b1;
        carry_next.empty_idx = idx;
      end
      if (!carry_in.lru_seen || (frame_rank > carry_in.lru_rank)) begin
        carry_next.lru_seen = 1'b1;
        carry_next.lru_idx  = idx;
        carry_next.lru_rank = frame_rank;
        carry_next.lru_page = frame_page;
      end
    end
  end

  assign sel = (upd.sel_idx == idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      frame_rank  <= '0;
    end else if (upd.en) begin
      if (sel) begin
        frame_rank <= '0;
        if (upd.set_valid) begin
          frame_valid <= 1'b1;
        end
      end else if (frame_valid && (upd.age_all || (frame_rank < upd.old_rank))) begin
        frame_rank <= frame_rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && sel && upd.set_page) begin
      frame_page <= upd.page;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lru_page_replacement_core.sv
// ----------------------------------------------------------------------------
// LRU page replacement core
// Fully associative frame store with least-recently-used replacement, built
// as a chain of frame cells that a search record walks through.
// ----------------------------------------------------------------------------
// Flow: a new page reference is taken only when the core is idle, after the
//   previous result has been loaded. The search record steps through one
//   frame cell per cycle along the chain.
// Reset: all frames empty, ranks zero, counters zero, 16 frames in use,
//   no result pending.
`default_nettype none

module lru_page_replacement_core
  import lrupr_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  // Page reference channel.
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] page,
  // Result channel.
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  outcome,
  output logic [3:0]  frame_index,
  output logic        evicted_valid,
  output logic [15:0] evicted_page,
  output logic [31:0] hit_count,
  output logic [31:0] fault_count,
  // Configuration channel: frames in use.
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [4:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  // Active frame mask, derived from the frames-in-use register when it is
  // written. A value of zero acts as one frame, a value above FRAMES as all.
  logic [FRAMES-1:0] act_mask, act_mask_next;

  // Page of the reference under search, broadcast to every cell.
  page_t pg;
  logic  start;

  // Search chain: tok[i] and carry[i] feed cell i; the last entries are the
  // finished search.
  logic  [FRAMES:0] tok;
  scan_t            carry [FRAMES+1];
  scan_t            fin;
  upd_t             upd;

  logic  in_xfer, out_xfer, cfg_xfer;
  logic  slot_free, finish;

  logic [31:0] hits, faults;

  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // The result register is free when it is empty or its transfer happens now.
  assign slot_free = !out_valid || out_ready;

  // The update is applied and the result loaded once the search record has
  // left the last cell, as soon as the result register can take it.
  assign finish = slot_free && (((state == ST_SCAN) && tok[FRAMES]) || (state == ST_HOLD));

  // ---------------------------------------------------------------------------
  // Configuration: turn the written count into a mask of frames in use.
  // ---------------------------------------------------------------------------
  always_comb begin
    int n;
    n = int'(cfg_data);
    if (n == 0) begin
      n = 1;
    end
    if (n > FRAMES) begin
      n = FRAMES;
    end
    for (int i = 0; i < FRAMES; i++) begin
      act_mask_next[i] = (i < n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_mask <= '1;
    end else if (cfg_xfer) begin
      act_mask <= act_mask_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[FRAMES]) begin
          state_next = slot_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pg <= PAGE_BITS'(page);
    end
  end

  // ---------------------------------------------------------------------------
  // Frame cell chain. The record entering cell 0 is empty; each cell adds the
  // first hit, the first empty frame and the oldest frame among those in use.
  // ---------------------------------------------------------------------------
  assign tok[0]   = start;
  assign carry[0] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrupr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (IDX_W'(i)),
      .active    (act_mask[i]),
      .tok_in    (tok[i]),
      .page_in   (pg),
      .carry_in  (carry[i]),
      .upd       (upd),
      .tok_out   (tok[i+1]),
      .carry_out (carry[i+1])
    );
  end

  assign fin = carry[FRAMES];

  // ---------------------------------------------------------------------------
  // Decision. A hit makes its frame most recent. A fault with an empty frame
  // fills the lowest-numbered one and ages every valid frame. Otherwise the
  // oldest frame in use is replaced and becomes most recent; in both touch
  // cases only the frames younger than the touched one age.
  // ---------------------------------------------------------------------------
  always_comb begin
    upd          = '0;
    upd.en       = finish;
    upd.page     = pg;
    if (fin.hit) begin
      upd.sel_idx  = fin.hit_idx;
      upd.old_rank = fin.hit_rank;
    end else if (fin.empty) begin
      upd.sel_idx   = fin.empty_idx;
      upd.set_page  = 1'b1;
      upd.set_valid = 1'b1;
      upd.age_all   = 1'b1;
    end else begin
      upd.sel_idx  = fin.lru_idx;
      upd.old_rank = fin.lru_rank;
      upd.set_page = 1'b1;
    end
  end

  // Saturating running counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      hits   <= '0;
      faults <= '0;
    end else if (finish) begin
      if (fin.hit) begin
        if (hits != '1) begin
          hits <= hits + 32'd1;
        end
      end else if (faults != '1) begin
        faults <= faults + 32'd1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      frame_index <= 4'(upd.sel_idx);
      if (fin.hit) begin
        outcome       <= OC_HIT;
        evicted_valid <= 1'b0;
        evicted_page  <= '0;
      end else if (fin.empty) begin
        outcome       <= OC_FILL;
        evicted_valid <= 1'b0;
        evicted_page  <= '0;
      end else begin
        outcome       <= OC_REPLACE;
        evicted_valid <= 1'b1;
        evicted_page  <= 16'(fin.lru_page);
      end
    end
  end

  // The counts shown belong to the result; they move only when one is loaded.
  assign hit_count   = hits;
  assign fault_count = faults;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok) <= 1)
    else $error("more than one search record in the frame chain");

  a_token_scan_only: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |-> (tok == '0))
    else $error("search record in the chain outside of a search");

  a_result_after_search: assert property (@(posedge clk) disable iff (rst)
    (!out_valid ##1 out_valid) |-> ($past(state) == ST_SCAN || $past(state) == ST_HOLD))
    else $error("result appeared without a finished search");

  a_evict_matches_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (evicted_valid == (outcome == OC_REPLACE)))
    else $error("eviction flag disagrees with outcome");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// LRU page replacement core testbench
// Streams page references into the core and checks each transfer on the
// result channel against a cycle-free model of the frame store. The model
// tracks the page, valid mark and age rank of every frame along with the
// running hit and fault counts. The run covers directed cold fill, frame
// count limits and randomized working-set traffic under several frame
// counts, with bursty input and stalling output.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import lrupr_pkg::*;
();

  // Even with the longest sender gaps and receiver stalls, a correct run
  // stays well inside this limit.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * (FRAMES + 2);
  localparam int RANDOM_ITEMS = 120;   // per random phase, ten phases

  // One expected transfer on the result channel.
  typedef struct {
    outcome_t    outcome;
    idx_t        frame;
    logic        evicted;
    page_t       evicted_page;
    logic [31:0] hits;
    logic [31:0] faults;
  } lookup_t;

  // Every input of the core holds a known value from time zero on.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [15:0] page      = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  outcome;
  logic [3:0]  frame_index;
  logic        evicted_valid;
  logic [15:0] evicted_page;
  logic [31:0] hit_count;
  logic [31:0] fault_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data  = '0;

  // Model of the frame store. These start out as the core comes out of
  // reset: all frames empty, ranks and counts zero, sixteen frames in use.
  page_t       resident_page  [FRAMES] = '{default: '0};
  logic        resident_valid [FRAMES] = '{default: 1'b0};
  rank_t       age_rank       [FRAMES] = '{default: '0};
  logic [31:0] hits_seen      = '0;
  logic [31:0] faults_seen    = '0;
  logic [4:0]  frames_setting = 5'd16;

  lookup_t     expected_lookups [$];
  lookup_t     oldest;
  int          mismatches  = 0;
  int          cycles      = 0;

  // Sender and receiver pacing.
  int          burst_left  = 0;
  logic        sender_calm = 1'b1;
  int          stall_mode  = 0;
  int          stall_run   = 0;

  lru_page_replacement_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page          (page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .outcome       (outcome),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .hit_count     (hit_count),
    .fault_count   (fault_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Frame store model
  // --------------------------------------------------------------------------

  // A register value of zero behaves as one frame, and anything above the
  // number of frames behaves as all of them.
  function automatic int frames_active(logic [4:0] setting);
    if (setting == 0) return 1;
    if (setting > FRAMES) return FRAMES;
    return setting;
  endfunction

  // Make frame f the most recent. Only valid frames younger than f age, so
  // the ranks of valid frames stay distinct. Frames beyond the count in use
  // age here as well.
  function automatic void promote(int f);
    rank_t was;
    was = age_rank[f];
    for (int i = 0; i < FRAMES; i++)
      if (i != f && resident_valid[i] && age_rank[i] < was)
        age_rank[i] = age_rank[i] + 1'b1;
    age_rank[f] = '0;
  endfunction

  // Look one page up, update the model and return what the core must report.
  function automatic lookup_t predict_lookup(page_t pg);
    lookup_t r;
    int      n;
    int      f;
    n = frames_active(frames_setting);
    f = -1;
    r.outcome      = OC_HIT;
    r.evicted      = 1'b0;
    r.evicted_page = '0;
    // Only frames in use are searched, lowest index first.
    for (int i = 0; i < n; i++)
      if (f < 0 && resident_valid[i] && resident_page[i] == pg)
        f = i;
    if (f >= 0) begin
      hits_seen = (hits_seen == 32'hFFFF_FFFF) ? hits_seen : hits_seen + 1;
      promote(f);
    end else begin
      faults_seen = (faults_seen == 32'hFFFF_FFFF) ? faults_seen : faults_seen + 1;
      for (int i = 0; i < n; i++)
        if (f < 0 && !resident_valid[i])
          f = i;
      if (f >= 0) begin
        // Filling an empty frame ages every valid frame, in use or not.
        r.outcome = OC_FILL;
        for (int i = 0; i < FRAMES; i++)
          if (resident_valid[i])
            age_rank[i] = age_rank[i] + 1'b1;
        resident_valid[f] = 1'b1;
        resident_page[f]  = pg;
        age_rank[f]       = '0;
      end else begin
        // Replace the oldest frame in use; ties go to the lowest index.
        r.outcome = OC_REPLACE;
        f = 0;
        for (int i = 1; i < n; i++)
          if (age_rank[i] > age_rank[f])
            f = i;
        r.evicted        = 1'b1;
        r.evicted_page   = resident_page[f];
        resident_page[f] = pg;
        promote(f);
      end
    end
    r.frame  = idx_t'(f);
    r.hits   = hits_seen;
    r.faults = faults_seen;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared tasks
  // --------------------------------------------------------------------------

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50)
      $display("ERROR cycle %0d: %s", cycles, msg);
  endtask

  // Sends one page reference. The sender works in bursts: when a burst is
  // used up it may drop valid for a random gap before the next one starts.
  // Valid is left high on return so that back-to-back references keep it
  // asserted without a drop inside the same time step.
  task automatic send_reference(page_t pg);
    int gap;
    if (burst_left == 0) begin
      gap = sender_calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    page     <= pg;
    do @(posedge clk); while (!in_ready);
    // The transfer took place at this edge, so the model steps now.
    expected_lookups.push_back(predict_lookup(pg));
  endtask

  // Stops the sender and waits until every expected result has arrived.
  task automatic finish_phase();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (expected_lookups.size() != 0) @(posedge clk);
  endtask

  // Writes the frame count, only once the core has gone idle. Every
  // reference produces a result, so an empty queue means nothing is in flight.
  task automatic write_frames(logic [4:0] value);
    finish_phase();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    frames_setting = value;
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // From reset with all sixteen frames: fill every frame, hit on a resident
  // page, then force two replacements of the least recently used frame.
  // Page numbers at both ends of the range are included.
  task automatic test_cold_fill();
    sender_calm = 1'b1;
    stall_mode  = 0;
    send_reference(16'h0000);
    send_reference(16'hFFFF);
    send_reference(16'h0000);
    for (int p = 1; p <= 13; p++)
      send_reference(page_t'(p));
    send_reference(16'h5555);   // last empty frame
    send_reference(16'hAAAA);   // store full: evicts the oldest page
    send_reference(16'hFFFF);   // that page comes back by another eviction
  endtask

  // The frame count register at its limits. With zero or one frame in use,
  // only frame 0 is searched and replaced while the other frames keep their
  // pages. Opening back up to all frames must find those pages again.
  task automatic test_frame_limits();
    stall_mode = 1;
    write_frames(5'd0);
    send_reference(16'h1234);
    send_reference(16'h1234);
    write_frames(5'd31);
    send_reference(16'h0003);   // parked while the count was shrunk
    send_reference(16'h1234);
    write_frames(5'd17);
    send_reference(16'h8000);
    write_frames(5'd1);
    send_reference(16'h0005);   // resident in frame 6, but not searched
  endtask

  // Randomized traffic, one phase per frame count. Most references come
  // from a working set sized near the frame count, so hits, fills and
  // replacements all occur often. Repeats and full-range random pages mix in.
  task automatic test_random_traffic();
    logic [4:0] settings [10];
    page_t      pool [32];
    page_t      pick;
    page_t      last_pick;
    int         n;
    int         lo;
    int         pool_size;
    int         roll;
    settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd3, 5'd12, 5'd2, 5'd16};
    settings[6] = 5'($urandom_range(0, 31));
    settings[7] = 5'($urandom_range(2, 15));
    last_pick = '0;
    for (int ph = 0; ph < 10; ph++) begin
      write_frames(settings[ph]);
      // Pacing rotates so that one phase runs with no idling at all.
      stall_mode  = ph % 3;
      sender_calm = (ph % 4 == 0);
      n  = frames_active(settings[ph]);
      lo = (n > 2) ? n - 2 : 1;
      pool_size = $urandom_range(lo, n + 5);
      for (int k = 0; k < 32; k++)
        pool[k] = page_t'($urandom);
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 15);
        if (roll < 12)
          pick = pool[$urandom_range(0, pool_size - 1)];
        else if (roll < 14)
          pick = last_pick;
        else
          pick = page_t'($urandom);
        send_reference(pick);
        last_pick = pick;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking and receiver pacing
  // --------------------------------------------------------------------------

  // Each transfer on the result channel is held against the oldest
  // expectation. Signals are sampled at the edge before the core updates.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_lookups.size() == 0) begin
        flag_mismatch("result transfer with no reference pending");
      end else begin
        oldest = expected_lookups.pop_front();
        if (outcome !== oldest.outcome)
          flag_mismatch($sformatf("outcome %0d, expected %0d", outcome, oldest.outcome));
        if (frame_index !== oldest.frame)
          flag_mismatch($sformatf("frame_index %0d, expected %0d",
                                  frame_index, oldest.frame));
        if (evicted_valid !== oldest.evicted)
          flag_mismatch($sformatf("evicted_valid %0b, expected %0b",
                                  evicted_valid, oldest.evicted));
        if (evicted_page !== oldest.evicted_page)
          flag_mismatch($sformatf("evicted_page %h, expected %h",
                                  evicted_page, oldest.evicted_page));
        if (hit_count !== oldest.hits)
          flag_mismatch($sformatf("hit_count %0d, expected %0d", hit_count, oldest.hits));
        if (fault_count !== oldest.faults)
          flag_mismatch($sformatf("fault_count %0d, expected %0d",
                                  fault_count, oldest.faults));
      end
    end
  end

  // Receiver ready: always high, randomly low about a quarter of the time,
  // or held in long high and low runs so that stalls span whole searches.
  always @(posedge clk) begin
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (stall_run == 0) begin
          stall_run <= $urandom_range(1, 30);
          out_ready <= ~out_ready;
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lru_page_replacement_core: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_cold_fill();
    test_frame_limits();
    test_random_traffic();
    finish_phase();
    // Give a stray late result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("lru_page_replacement_core: match");
    else
      $display("lru_page_replacement_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
